// File: src/mru_history_list_with_dedup_assert.svh
// Assertion macros shared by the history list RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef MRU_HISTORY_LIST_WITH_DEDUP_ASSERT_SVH
`define MRU_HISTORY_LIST_WITH_DEDUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mhl_pkg.sv
// Package for the most-recent-first history list: field widths, payload structs,
// mode codes, cell operations and controller states. No dependencies.
package mhl_pkg;

    localparam int ID_W          = 32;
    localparam int KIND_W        = 2;
    localparam int HASH_W        = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_OUT_W     = 7;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_PROMOTE = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IMAGE = 2'd1;

    typedef struct packed {
        mode_t               mode;
        logic [ID_W-1:0]     item_id;
        logic [KIND_W-1:0]   item_kind;
        logic [HASH_W-1:0]   data_hash;
        logic [IDX_W-1:0]    slot_index;
    } req_t;

    typedef struct packed {
        logic                 inserted;
        logic                 promoted;
        logic                 removed;
        logic [ID_W-1:0]      refused_id;
        logic [ID_W-1:0]      dropped_id;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_t;

    // One list slot; the kind is stored as a single bit since only text and image are held.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              kind;
        logic [HASH_W-1:0] hash;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LEFT,
        OP_RIGHT,
        OP_ZERO
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

endpackage

// File: src/mhl_cell.sv
// One slot of the history list chain: holds an entry and its duplicate-match flag.
// Depends on mhl_pkg.
module mhl_cell #(
    parameter int DEPTH = mhl_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              capture,
    input  logic [mhl_pkg::KIND_W-1:0]        kind,
    input  logic [mhl_pkg::HASH_W-1:0]        hash,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  mhl_pkg::cell_op_t                 op,
    input  mhl_pkg::entry_t                   left_entry,
    input  mhl_pkg::entry_t                   right_entry,
    output mhl_pkg::entry_t                   entry,
    output logic                              hit
);
    import mhl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit_reg;
    logic   hit_next;
    logic   occupied;

    assign occupied = CNT_W'(IDX) < count;

    always_comb
    begin
        case (op)
            OP_HOLD:  entry_next = entry_reg;
            OP_LEFT:  entry_next = left_entry;
            OP_RIGHT: entry_next = right_entry;
            OP_ZERO:  entry_next = '0;
            default:  entry_next = entry_reg;
        endcase
    end

    // The match flag is taken when a transaction is accepted and used on the following shift.
    always_comb
    begin
        hit_next = hit_reg;
        if (capture)
        begin
            hit_next = occupied
                && ({{(KIND_W-1){1'b0}}, entry_reg.kind} == kind)
                && (entry_reg.hash == hash);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// File: src/mhl_ctrl.sv
// Controller of the history list: handshakes, fill count, per-cell shift
// commands and result formation. Depends on mhl_pkg and the assertion header.
`include "mru_history_list_with_dedup_assert.svh"

module mhl_ctrl #(
    parameter int DEPTH = mhl_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mhl_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output mhl_pkg::rsp_t               rsp,
    output logic                        capture,
    output logic [$clog2(DEPTH+1)-1:0]  count,
    input  logic [DEPTH-1:0]            hits,
    input  mhl_pkg::entry_t             entries [DEPTH],
    output mhl_pkg::cell_op_t           ops [DEPTH],
    output mhl_pkg::entry_t             front
);
    import mhl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    req_t             req_reg;
    req_t             req_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;

    logic             fire;
    logic             full;
    logic             idx_ok;
    logic             bad_ins;
    logic             dup;
    logic             new_ins;
    logic             mv_front;
    logic             do_rem;
    logic             clr;
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] sel_idx;
    logic [DEPTH-1:0] tgt;
    logic [DEPTH-1:0] at_or_below;
    logic [DEPTH-1:0] at_or_above;
    entry_t           picked;

    assign req_ready = (state_reg == ST_IDLE);
    assign capture   = req_valid && req_ready;
    assign fire      = (state_reg == ST_SHIFT) && (!rsp_valid_reg || rsp_ready);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign idx_ok    = {1'b0, req_reg.slot_index} < CNT_OUT_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (capture)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Mode decode and target selection for the shift cycle.
    always_comb
    begin
        logic seen;
        logic run;
        seen    = 1'b0;
        bad_ins = (req_reg.mode == MODE_INSERT)
            && ((req_reg.item_id == '0) || (req_reg.item_kind > KIND_IMAGE));
        for (int c = 0; c < DEPTH; c++)
        begin
            first_hit[c] = hits[c] && !seen;
            seen         = seen || hits[c];
            sel_idx[c]   = (req_reg.slot_index == IDX_W'(c)) && idx_ok;
        end
        dup      = (req_reg.mode == MODE_INSERT) && !bad_ins
            && (req_reg.data_hash != '0) && seen;
        new_ins  = (req_reg.mode == MODE_INSERT) && !bad_ins && !dup;
        mv_front = dup || ((req_reg.mode == MODE_PROMOTE) && idx_ok);
        do_rem   = (req_reg.mode == MODE_REMOVE) && idx_ok;
        clr      = (req_reg.mode == MODE_CLEAR);
        tgt      = (req_reg.mode == MODE_INSERT) ? first_hit : sel_idx;

        // Cells at or in front of the target slide back on a move to front;
        // cells at or behind it slide forward on a remove.
        run = 1'b0;
        for (int c = DEPTH - 1; c >= 0; c--)
        begin
            run            = run || tgt[c];
            at_or_below[c] = run;
        end
        run = 1'b0;
        for (int c = 0; c < DEPTH; c++)
        begin
            run            = run || tgt[c];
            at_or_above[c] = run;
        end

        picked = '0;
        for (int c = 0; c < DEPTH; c++)
        begin
            if (tgt[c])
            begin
                picked = picked | entries[c];
            end
        end
    end

    // Outputs: cell commands, front entry, count update and the result.
    always_comb
    begin
        for (int c = 0; c < DEPTH; c++)
        begin
            ops[c] = OP_HOLD;
            if (fire)
            begin
                if (clr)
                begin
                    ops[c] = OP_ZERO;
                end
                else if (new_ins)
                begin
                    ops[c] = OP_LEFT;
                end
                else if (mv_front && ((c == 0) || at_or_below[c]))
                begin
                    ops[c] = OP_LEFT;
                end
                else if (do_rem && at_or_above[c])
                begin
                    ops[c] = OP_RIGHT;
                end
            end
        end

        if (new_ins)
        begin
            front.id   = req_reg.item_id;
            front.kind = req_reg.item_kind[0];
            front.hash = req_reg.data_hash;
        end
        else
        begin
            front = picked;
        end

        count_after = count_reg;
        if (clr)
        begin
            count_after = '0;
        end
        else if (new_ins && !full)
        begin
            count_after = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_after = count_reg - 1'b1;
        end
        count_next = fire ? count_after : count_reg;

        rsp_next = rsp_reg;
        if (fire)
        begin
            rsp_next.inserted    = new_ins;
            rsp_next.promoted    = mv_front;
            rsp_next.removed     = do_rem;
            rsp_next.refused_id  = (bad_ins || dup) ? req_reg.item_id : '0;
            rsp_next.dropped_id  = (new_ins && full) ? entries[DEPTH-1].id : '0;
            rsp_next.entry_count = CNT_OUT_W'(count_after);
        end

        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end

        req_next = capture ? req : req_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;

    `MHL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `MHL_ASSERT_NOW(a_one_action, fire, $onehot0({new_ins, mv_front, do_rem, clr}), "several list actions at once")
    `MHL_ASSERT_NOW(a_one_target, state_reg == ST_SHIFT, $onehot0(tgt), "more than one target slot")
    `MHL_ASSERT_NEXT(a_grow, fire && new_ins && !full, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow the list")
    `MHL_ASSERT_NEXT(a_wait, (state_reg == ST_SHIFT) && !fire, rsp_valid_reg && $stable(rsp_reg), "held result changed while stalled")

endmodule

// File: src/mru_history_list_with_dedup.sv
// An accepted request moves the controller to its shift state; rsp_valid rises with the shift.
// Each transaction compares in every cell, then shifts the chain; no request is accepted while
// a shift waits; a result not yet taken delays the shift of the following transaction.
// Reset: rst_n asynchronously empties the list, zeroes every cell and drops rsp_valid.
// Top level of the most-recent-first history list; depends on mhl_pkg, mhl_cell, mhl_ctrl.
module mru_history_list_with_dedup #(
    parameter int DEPTH = mhl_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mhl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mhl_pkg::rsp_t rsp
);
    import mhl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             capture;
    logic [CNT_W-1:0] count;
    logic [DEPTH-1:0] hits;
    entry_t           entries [DEPTH];
    cell_op_t         ops [DEPTH];
    entry_t           front;

    mhl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .capture   (capture),
        .count     (count),
        .hits      (hits),
        .entries   (entries),
        .ops       (ops),
        .front     (front)
    );

    for (genvar c = 0; c < DEPTH; c++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;

        if (c == 0)
        begin : g_head
            assign left_entry = front;
        end
        else
        begin : g_body
            assign left_entry = entries[c-1];
        end

        if (c == DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_next
            assign right_entry = entries[c+1];
        end

        mhl_cell #(
            .DEPTH (DEPTH),
            .IDX   (c)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .capture     (capture),
            .kind        (req.item_kind),
            .hash        (req.data_hash),
            .count       (count),
            .op          (ops[c]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[c]),
            .hit         (hits[c])
        );
    end

endmodule

// File: dv/tb_mru_history_list_with_dedup.sv
// Self-checking testbench for the most-recent-first history list with duplicate matching.
// Depends on mhl_pkg and the mru_history_list_with_dedup RTL; the predictor below is its own.
`timescale 1ns / 1ps

module tb_mru_history_list_with_dedup;
    import mhl_pkg::*;

    localparam int HIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_FROM    = 540;
    localparam int CYCLE_LIMIT  = 200000;
    localparam rsp_t RSP_NONE   = '0;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b1;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    entry_t   hist [HIST_DEPTH];
    int       hist_count;
    rsp_t     outcome_q [$];
    dir_row_t dir_rows [$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    bit       no_idle     = 1'b0;

    mru_history_list_with_dedup #(
        .DEPTH(HIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    function automatic void bring_to_front(int pos);
        entry_t moved;
        int     c;
        moved = hist[pos];
        for (c = pos; c > 0; c--)
        begin
            hist[c] = hist[c - 1];
        end
        hist[0] = moved;
    endfunction

    // Updates the shadow list for one transaction and returns the response it should produce.
    function automatic rsp_t apply_to_history(req_t r);
        rsp_t o;
        int   hit;
        int   c;
        o   = '0;
        hit = -1;
        case (r.mode)
            MODE_INSERT:
            begin
                if (r.item_id == '0 || r.item_kind > KIND_IMAGE)
                begin
                    o.refused_id = r.item_id;
                end
                else
                begin
                    if (r.data_hash != '0)
                    begin
                        for (c = 0; c < hist_count; c++)
                        begin
                            if (hit < 0 && hist[c].kind == r.item_kind[0] &&
                                hist[c].hash == r.data_hash)
                            begin
                                hit = c;
                            end
                        end
                    end
                    if (hit >= 0)
                    begin
                        o.refused_id = r.item_id;
                        o.promoted   = 1'b1;
                        bring_to_front(hit);
                    end
                    else
                    begin
                        if (hist_count == HIST_DEPTH)
                        begin
                            o.dropped_id = hist[HIST_DEPTH - 1].id;
                        end
                        else
                        begin
                            hist_count++;
                        end
                        for (c = hist_count - 1; c > 0; c--)
                        begin
                            hist[c] = hist[c - 1];
                        end
                        hist[0].id   = r.item_id;
                        hist[0].kind = r.item_kind[0];
                        hist[0].hash = r.data_hash;
                        o.inserted   = 1'b1;
                    end
                end
            end
            MODE_PROMOTE:
            begin
                if (r.slot_index < hist_count)
                begin
                    bring_to_front(r.slot_index);
                    o.promoted = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (r.slot_index < hist_count)
                begin
                    for (c = r.slot_index; c + 1 < hist_count; c++)
                    begin
                        hist[c] = hist[c + 1];
                    end
                    hist_count--;
                    hist[hist_count] = '0;
                    o.removed = 1'b1;
                end
            end
            default:
            begin
                for (c = 0; c < HIST_DEPTH; c++)
                begin
                    hist[c] = '0;
                end
                hist_count = 0;
            end
        endcase
        o.entry_count = hist_count[CNT_OUT_W-1:0];
        return o;
    endfunction

    function automatic void add_step(mode_t m, logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                                     logic [HASH_W-1:0] hash, logic [IDX_W-1:0] idx,
                                     bit typed, rsp_t want);
        dir_row_t d;
        d.r.mode       = m;
        d.r.item_id    = id;
        d.r.item_kind  = kind;
        d.r.data_hash  = hash;
        d.r.slot_index = idx;
        d.typed        = typed;
        d.want         = want;
        dir_rows.push_back(d);
    endfunction

    // Mostly well-formed traffic: inserts that often hit held hashes, in-range indexes,
    // rare clears so the list fills and evicts; the rest is malformed or out of range.
    function automatic req_t make_random_req();
        req_t r;
        int   pick;
        int   j;
        r.item_id    = $urandom;
        r.item_kind  = KIND_W'($urandom_range(0, 3));
        r.data_hash  = {$urandom, $urandom};
        r.slot_index = IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            r.mode = MODE_INSERT;
            if ($urandom_range(0, 29) == 0)
            begin
                r.item_id = '0;
            end
            if ($urandom_range(0, 11) != 0)
            begin
                r.item_kind = KIND_W'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 30 && hist_count > 0)
            begin
                j = $urandom_range(0, hist_count - 1);
                r.data_hash = hist[j].hash;
                r.item_kind = {1'b0, hist[j].kind};
            end
            else if (pick < 40)
            begin
                r.data_hash = '0;
            end
            else if (pick < 55)
            begin
                r.data_hash = HASH_W'($urandom_range(1, 4));
            end
        end
        else
        begin
            if (pick < 76)
            begin
                r.mode = MODE_PROMOTE;
            end
            else if (pick < 98)
            begin
                r.mode = MODE_REMOVE;
            end
            else
            begin
                r.mode = MODE_CLEAR;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                r.slot_index = IDX_W'($urandom_range(0, hist_count));
            end
        end
        return r;
    endfunction

    task automatic send_req(req_t r, bit typed, rsp_t want);
        rsp_t predicted;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predicted = apply_to_history(r);
        outcome_q.push_back(typed ? want : predicted);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t ns: unexpected response transaction, actual %0h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                cmp_field("inserted", want.inserted, rsp.inserted);
                cmp_field("promoted", want.promoted, rsp.promoted);
                cmp_field("removed", want.removed, rsp.removed);
                cmp_field("refused_id", want.refused_id, rsp.refused_id);
                cmp_field("dropped_id", want.dropped_id, rsp.dropped_id);
                cmp_field("entry_count", want.entry_count, rsp.entry_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int n;
        for (n = 0; n < HIST_DEPTH; n++)
        begin
            hist[n] = '0;
        end
        hist_count = 0;

        // Empty list, rejected inserts, zero and all-ones hashes, one hash under both kinds, a duplicate,
        // promote at the front, out-of-range indexes, clear, then the widest id.
        add_step(MODE_REMOVE, '0, KIND_TEXT, '0, '0, 1, RSP_NONE);
        add_step(MODE_PROMOTE, '1, 2'd3, '1, '0, 1, RSP_NONE);
        add_step(MODE_INSERT, '0, KIND_TEXT, 64'd5, '0, 1, RSP_NONE);
        add_step(MODE_INSERT, 32'd5, 2'd2, 64'd7, '0, 1,
                 rsp_t'{1'b0, 1'b0, 1'b0, 32'd5, 32'd0, 7'd0});
        add_step(MODE_INSERT, '1, 2'd3, '1, '1, 1,
                 rsp_t'{1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd0, 7'd0});
        add_step(MODE_INSERT, 32'd1, KIND_TEXT, '0, '0, 1,
                 rsp_t'{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 7'd1});
        add_step(MODE_INSERT, 32'd2, KIND_TEXT, '0, '0, 1,
                 rsp_t'{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 7'd2});
        add_step(MODE_INSERT, 32'd3, KIND_IMAGE, '1, '0, 1,
                 rsp_t'{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 7'd3});
        add_step(MODE_INSERT, 32'd4, KIND_TEXT, '1, '0, 1,
                 rsp_t'{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 7'd4});
        add_step(MODE_INSERT, 32'd5, KIND_IMAGE, '1, '0, 1,
                 rsp_t'{1'b0, 1'b1, 1'b0, 32'd5, 32'd0, 7'd4});
        add_step(MODE_PROMOTE, 32'd9, KIND_TEXT, 64'd9, 6'd3, 0, RSP_NONE);
        add_step(MODE_PROMOTE, '0, KIND_TEXT, '0, 6'd0, 1,
                 rsp_t'{1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 7'd4});
        add_step(MODE_PROMOTE, '0, KIND_TEXT, '0, '1, 1,
                 rsp_t'{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 7'd4});
        add_step(MODE_REMOVE, '1, 2'd3, '1, 6'd4, 1,
                 rsp_t'{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 7'd4});
        add_step(MODE_REMOVE, '0, KIND_TEXT, '0, 6'd1, 1,
                 rsp_t'{1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 7'd3});
        add_step(MODE_REMOVE, '0, KIND_TEXT, '0, 6'd2, 0, RSP_NONE);
        add_step(MODE_INSERT, 32'h8000_0000, KIND_IMAGE, 64'h8000_0000_0000_0001, '0, 0,
                 RSP_NONE);
        add_step(MODE_INSERT, 32'd6, KIND_TEXT, '1, '0, 0, RSP_NONE);
        add_step(MODE_CLEAR, '1, 2'd3, '1, '1, 1, RSP_NONE);
        add_step(MODE_INSERT, '1, KIND_IMAGE, 64'd1, '0, 1,
                 rsp_t'{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 7'd1});
        add_step(MODE_REMOVE, '0, KIND_TEXT, '0, 6'd0, 1,
                 rsp_t'{1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 7'd0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n % 150 >= 120) || (n >= CALM_FROM);
            // Hold off now and then until every outstanding response has been taken.
            if (n % 200 == 100)
            begin
                req_valid <= 1'b0;
                wait_drained();
            end
            send_req(make_random_req(), 1'b0, RSP_NONE);
        end
        req_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
